// ----- hw/rtl/plds_pkg.sv -----
package plds_pkg;

    // Field widths at the ports.
    localparam int COORD_W    = 32;
    localparam int NORM_W     = 16;
    localparam int SUM_W      = 32;
    localparam int COEF_W     = 32;
    localparam int INTEN_W    = 16;
    localparam int SF_W       = 16;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    // Fractional bits of the fixed-point formats.
    localparam int Q16_FRAC = 16;
    localparam int Q15_FRAC = 15;
    localparam int Q8_FRAC  = 8;

    // Geometry: light vector, half-precision squares and the normal product.
    localparam int DIFF_W      = COORD_W + 1;
    localparam int HALF_W      = DIFF_W - 1;
    localparam int SQ_W        = 2 * HALF_W;
    localparam int PROD_W      = NORM_W + DIFF_W;
    localparam int NDOT_W      = PROD_W + 1;
    localparam int SQRT_STAGES = SQ_W / 2;
    localparam int DIST_W      = SQRT_STAGES + 1;

    // Attenuation terms saturate at 2^40.
    localparam int ATT_CAP_W = 41;
    localparam logic [ATT_CAP_W-1:0] ATT_CAP = 41'h100_0000_0000;
    localparam int DENOM_W = ATT_CAP_W + 1;

    // Shared restoring divider: both quotients are known to stay below 2^21.
    localparam int DIV_N_W   = NDOT_W;
    localparam int DIV_D_W   = DENOM_W;
    localparam int DIV_Q_W   = 21;
    localparam int DIV_CMP_W = DIV_D_W + DIV_Q_W - 1;
    localparam logic [DIV_N_W-1:0] ATT_NUM = DIV_N_W'(64'h1_0000_0000);

    // Shading arithmetic.
    localparam int ATT_W     = 17;
    localparam int K_W       = 23;
    localparam int CONTRIB_W = 31;
    localparam logic [ATT_W-1:0] ONE_Q16 = 17'h1_0000;
    localparam logic [SF_W-1:0]  ONE_Q15 = 16'h8000;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTENSITY,
        CFG_POS_X,
        CFG_POS_Y,
        CFG_POS_Z,
        CFG_SHADOW,
        CFG_ATT_C,
        CFG_ATT_L,
        CFG_ATT_Q
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0]     intensity;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [SF_W-1:0]           shadow;
        logic [COEF_W-1:0]         att_c;
        logic [COEF_W-1:0]         att_l;
        logic [COEF_W-1:0]         att_q;
    } cfg_t;

    // Fields carried unchanged from input to the final stage.
    typedef struct packed {
        logic             obs_hit;
        logic [SUM_W-1:0] obs_dist;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
    } item_t;

    typedef struct packed {
        item_t                    item;
        logic signed [NDOT_W-1:0] ndot;
    } geo_t;

    typedef struct packed {
        item_t                    item;
        logic signed [NDOT_W-1:0] ndot;
        logic [DIST_W-1:0]        light_dist;
    } dist_t;

    typedef struct packed {
        item_t             item;
        logic              facing;
        logic              att_one;
        logic [DIST_W-1:0] light_dist;
    } divs_t;

    typedef struct packed {
        divs_t              side;
        logic [DIV_Q_W-1:0] lam;
        logic [DIV_Q_W-1:0] att_q;
    } quot_t;

endpackage

// ----- hw/rtl/point_light_diffuse_shade.sv -----
// Lambert diffuse shading from one configured point light.
// Input channel (in_valid/in_ready): a surface point, its normal, the shadow
// ray result and the running RGB sums. Output channel (out_valid/out_ready):
// the updated sums with the facing, shadow and saturation flags.
// Configuration: cfg_wen writes cfg_wdata into register cfg_idx at the clock
// edge; write only while no transaction is in flight.
// Depth: 64 register stages. Throughput is one transaction per cycle
// while the receiver does not stall; the 32-stage square root and the
// 21-stage divider pair set the depth.
// Every stage moves together: in_ready is high whenever the output register
// is empty or being read. When the receiver stalls, the whole pipeline holds
// and nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults: white light of
// intensity 1.0 at the origin, shadowing off, constant attenuation 1.0.
module point_light_diffuse_shade (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [plds_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [plds_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [plds_pkg::COORD_W-1:0]  surf_x,
    input  logic signed [plds_pkg::COORD_W-1:0]  surf_y,
    input  logic signed [plds_pkg::COORD_W-1:0]  surf_z,
    input  logic signed [plds_pkg::NORM_W-1:0]   norm_x,
    input  logic signed [plds_pkg::NORM_W-1:0]   norm_y,
    input  logic signed [plds_pkg::NORM_W-1:0]   norm_z,
    input  logic                                 obstruction_hit,
    input  logic [plds_pkg::SUM_W-1:0]           obstruction_dist,
    input  logic [plds_pkg::SUM_W-1:0]           sum_in_r,
    input  logic [plds_pkg::SUM_W-1:0]           sum_in_g,
    input  logic [plds_pkg::SUM_W-1:0]           sum_in_b,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [plds_pkg::SUM_W-1:0]           sum_out_r,
    output logic [plds_pkg::SUM_W-1:0]           sum_out_g,
    output logic [plds_pkg::SUM_W-1:0]           sum_out_b,
    output logic                                 facing_light,
    output logic                                 in_shadow,
    output logic                                 saturated
);
    import plds_pkg::*;

    cfg_t  cfg_reg;
    item_t item;
    logic  adv;

    logic                  geo_valid;
    logic [SQ_W-1:0]       sq_sum;
    geo_t                  geo;
    logic                  sqrt_valid;
    logic [DIST_W-1:0]     light_dist;
    geo_t                  geo_d;
    logic                  att_valid;
    logic [DENOM_W-1:0]    denom;
    dist_t                 carry;
    logic                  div_valid;
    quot_t                 quot;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.intensity <= 48'h0100_0100_0100;
            cfg_reg.pos_x     <= '0;
            cfg_reg.pos_y     <= '0;
            cfg_reg.pos_z     <= '0;
            cfg_reg.shadow    <= ONE_Q15;
            cfg_reg.att_c     <= COEF_W'(ONE_Q16);
            cfg_reg.att_l     <= '0;
            cfg_reg.att_q     <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_INTENSITY: cfg_reg.intensity <= cfg_wdata;
                CFG_POS_X:     cfg_reg.pos_x     <= cfg_wdata[COORD_W-1:0];
                CFG_POS_Y:     cfg_reg.pos_y     <= cfg_wdata[COORD_W-1:0];
                CFG_POS_Z:     cfg_reg.pos_z     <= cfg_wdata[COORD_W-1:0];
                CFG_SHADOW:    cfg_reg.shadow    <= cfg_wdata[SF_W-1:0];
                CFG_ATT_C:     cfg_reg.att_c     <= cfg_wdata[COEF_W-1:0];
                CFG_ATT_L:     cfg_reg.att_l     <= cfg_wdata[COEF_W-1:0];
                CFG_ATT_Q:     cfg_reg.att_q     <= cfg_wdata[COEF_W-1:0];
                default:       ;
            endcase
        end
    end

    // The pipeline advances whenever the output register can take a result.
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    assign item.obs_hit  = obstruction_hit;
    assign item.obs_dist = obstruction_dist;
    assign item.sum_r    = sum_in_r;
    assign item.sum_g    = sum_in_g;
    assign item.sum_b    = sum_in_b;

    plds_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .surf_x    (surf_x),
        .surf_y    (surf_y),
        .surf_z    (surf_z),
        .norm_x    (norm_x),
        .norm_y    (norm_y),
        .norm_z    (norm_z),
        .item      (item),
        .cfg       (cfg_reg),
        .out_valid (geo_valid),
        .sq_sum    (sq_sum),
        .geo       (geo)
    );

    plds_isqrt u_isqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (geo_valid),
        .sq_sum     (sq_sum),
        .geo        (geo),
        .out_valid  (sqrt_valid),
        .light_dist (light_dist),
        .geo_out    (geo_d)
    );

    plds_atten u_atten (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (sqrt_valid),
        .light_dist (light_dist),
        .geo        (geo_d),
        .cfg        (cfg_reg),
        .out_valid  (att_valid),
        .denom      (denom),
        .carry      (carry)
    );

    plds_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (att_valid),
        .denom     (denom),
        .carry     (carry),
        .out_valid (div_valid),
        .quot      (quot)
    );

    plds_shade u_shade (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (div_valid),
        .quot         (quot),
        .cfg          (cfg_reg),
        .out_valid    (out_valid),
        .sum_out_r    (sum_out_r),
        .sum_out_g    (sum_out_g),
        .sum_out_b    (sum_out_b),
        .facing_light (facing_light),
        .in_shadow    (in_shadow),
        .saturated    (saturated)
    );

endmodule

// ----- hw/rtl/plds_geom.sv -----
module plds_geom (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic signed [plds_pkg::COORD_W-1:0] surf_x,
    input  logic signed [plds_pkg::COORD_W-1:0] surf_y,
    input  logic signed [plds_pkg::COORD_W-1:0] surf_z,
    input  logic signed [plds_pkg::NORM_W-1:0]  norm_x,
    input  logic signed [plds_pkg::NORM_W-1:0]  norm_y,
    input  logic signed [plds_pkg::NORM_W-1:0]  norm_z,
    input  plds_pkg::item_t                     item,
    input  plds_pkg::cfg_t                      cfg,
    output logic                                out_valid,
    output logic [plds_pkg::SQ_W-1:0]           sq_sum,
    output plds_pkg::geo_t                      geo
);
    import plds_pkg::*;

    logic [2:0] v_reg;

    logic signed [COORD_W-1:0] pos [3];
    logic signed [COORD_W-1:0] surf [3];
    logic signed [NORM_W-1:0]  norm [3];

    logic signed [DIFF_W-1:0] d_next [3];
    logic signed [DIFF_W-1:0] d_reg  [3];
    logic signed [NORM_W-1:0] n_reg  [3];
    item_t                    item1_reg;

    logic [DIFF_W-1:0]        mag [3];
    logic [SQ_W-1:0]          sq_next [3];
    logic [SQ_W-1:0]          sq_reg  [3];
    logic signed [PROD_W-1:0] p_next  [3];
    logic signed [PROD_W-1:0] p_reg   [3];
    item_t                    item2_reg;

    logic [SQ_W-1:0]          sum_next;
    logic [SQ_W-1:0]          sum_reg;
    logic signed [NDOT_W-1:0] ndot_next;
    logic signed [NDOT_W-1:0] ndot_reg;
    item_t                    item3_reg;

    assign pos[0]  = cfg.pos_x;
    assign pos[1]  = cfg.pos_y;
    assign pos[2]  = cfg.pos_z;
    assign surf[0] = surf_x;
    assign surf[1] = surf_y;
    assign surf[2] = surf_z;
    assign norm[0] = norm_x;
    assign norm[1] = norm_y;
    assign norm[2] = norm_z;

    // First stage: exact vector from the surface point to the light.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            d_next[a] = DIFF_W'(pos[a]) - DIFF_W'(surf[a]);
        end
    end

    // Second stage: squares of the halved magnitudes and the normal products.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mag[a]     = d_reg[a][DIFF_W-1] ? -d_reg[a] : d_reg[a];
            sq_next[a] = SQ_W'(mag[a][DIFF_W-1:1]) * SQ_W'(mag[a][DIFF_W-1:1]);
            p_next[a]  = PROD_W'(n_reg[a]) * PROD_W'(d_reg[a]);
        end
    end

    // Third stage: sum of squares and the dot product.
    always_comb
    begin
        sum_next  = sq_reg[0] + sq_reg[1] + sq_reg[2];
        ndot_next = NDOT_W'(p_reg[0]) + NDOT_W'(p_reg[1]) + NDOT_W'(p_reg[2]);
    end

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                d_reg[a]  <= d_next[a];
                n_reg[a]  <= norm[a];
                sq_reg[a] <= sq_next[a];
                p_reg[a]  <= p_next[a];
            end
            item1_reg <= item;
            item2_reg <= item1_reg;
            sum_reg   <= sum_next;
            ndot_reg  <= ndot_next;
            item3_reg <= item2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign sq_sum    = sum_reg;
    assign geo.item  = item3_reg;
    assign geo.ndot  = ndot_reg;

endmodule

// ----- hw/rtl/plds_isqrt.sv -----
module plds_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [plds_pkg::SQ_W-1:0]   sq_sum,
    input  plds_pkg::geo_t              geo,
    output logic                        out_valid,
    output logic [plds_pkg::DIST_W-1:0] light_dist,
    output plds_pkg::geo_t              geo_out
);
    import plds_pkg::*;

    localparam int LAST = SQRT_STAGES - 1;

    logic [SQRT_STAGES-1:0] v_reg;
    logic [SQ_W-1:0]        x_next [SQRT_STAGES];
    logic [SQ_W-1:0]        x_reg  [SQRT_STAGES];
    logic [SQ_W-1:0]        r_next [SQRT_STAGES];
    logic [SQ_W-1:0]        r_reg  [SQRT_STAGES];
    geo_t                   geo_reg [SQRT_STAGES];

    // One result bit per stage, from the top pair of bits down.
    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_step
        localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * j);

        logic [SQ_W-1:0] x_in;
        logic [SQ_W-1:0] r_in;
        logic [SQ_W-1:0] t;
        logic            ge;
        geo_t            geo_in;

        if (j == 0)
        begin : g_first
            assign x_in   = sq_sum;
            assign r_in   = '0;
            assign geo_in = geo;
        end
        else
        begin : g_rest
            assign x_in   = x_reg[j-1];
            assign r_in   = r_reg[j-1];
            assign geo_in = geo_reg[j-1];
        end

        always_comb
        begin
            t         = r_in + STEP_BIT;
            ge        = x_in >= t;
            x_next[j] = ge ? x_in - t : x_in;
            r_next[j] = ge ? (r_in >> 1) + STEP_BIT : r_in >> 1;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[j]   <= x_next[j];
                r_reg[j]   <= r_next[j];
                geo_reg[j] <= geo_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[SQRT_STAGES-2:0], in_valid};
        end
    end

    // The root was taken of halved components, so the distance is doubled.
    assign out_valid  = v_reg[LAST];
    assign light_dist = {r_reg[LAST][DIST_W-2:0], 1'b0};
    assign geo_out    = geo_reg[LAST];

endmodule

// ----- hw/rtl/plds_atten.sv -----
module plds_atten (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [plds_pkg::DIST_W-1:0]  light_dist,
    input  plds_pkg::geo_t               geo,
    input  plds_pkg::cfg_t               cfg,
    output logic                         out_valid,
    output logic [plds_pkg::DENOM_W-1:0] denom,
    output plds_pkg::dist_t              carry
);
    import plds_pkg::*;

    localparam int PL_W  = COEF_W + DIST_W;
    localparam int PDD_W = 2 * DIST_W;
    localparam int PQ_W  = COEF_W + ATT_CAP_W;

    logic [3:0] v_reg;
    dist_t      c_in;

    logic [PL_W-1:0]      pl_next;
    logic [PL_W-1:0]      pl_reg;
    logic [PDD_W-1:0]     pdd_next;
    logic [PDD_W-1:0]     pdd_reg;
    dist_t                c1_reg;

    logic [ATT_CAP_W-1:0] ld_next;
    logic [ATT_CAP_W-1:0] ld_reg;
    logic [ATT_CAP_W-1:0] dd_next;
    logic [ATT_CAP_W-1:0] dd_reg;
    dist_t                c2_reg;

    logic [PQ_W-1:0]      pq_next;
    logic [PQ_W-1:0]      pq_reg;
    logic [ATT_CAP_W-1:0] ld3_reg;
    dist_t                c3_reg;

    logic [ATT_CAP_W-1:0] qt;
    logic [DENOM_W-1:0]   denom_next;
    logic [DENOM_W-1:0]   denom_reg;
    dist_t                c4_reg;

    assign c_in.item       = geo.item;
    assign c_in.ndot       = geo.ndot;
    assign c_in.light_dist = light_dist;

    // First stage: linear term product and the square of the distance.
    always_comb
    begin
        pl_next  = PL_W'(cfg.att_l) * PL_W'(light_dist);
        pdd_next = PDD_W'(light_dist) * PDD_W'(light_dist);
    end

    // Second stage: back to Q16.16 with saturation.
    always_comb
    begin
        ld_next = ((pl_reg >> Q16_FRAC) > PL_W'(ATT_CAP)) ? ATT_CAP
                : pl_reg[ATT_CAP_W+Q16_FRAC-1:Q16_FRAC];
        dd_next = ((pdd_reg >> Q16_FRAC) > PDD_W'(ATT_CAP)) ? ATT_CAP
                : pdd_reg[ATT_CAP_W+Q16_FRAC-1:Q16_FRAC];
    end

    // Third stage: quadratic term product.
    assign pq_next = PQ_W'(cfg.att_q) * PQ_W'(dd_reg);

    // Fourth stage: saturate the quadratic term and form the denominator.
    always_comb
    begin
        qt = ((pq_reg >> Q16_FRAC) > PQ_W'(ATT_CAP)) ? ATT_CAP
           : pq_reg[ATT_CAP_W+Q16_FRAC-1:Q16_FRAC];
        denom_next = DENOM_W'(cfg.att_c) + DENOM_W'(ld3_reg) + DENOM_W'(qt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pl_reg    <= pl_next;
            pdd_reg   <= pdd_next;
            c1_reg    <= c_in;
            ld_reg    <= ld_next;
            dd_reg    <= dd_next;
            c2_reg    <= c1_reg;
            pq_reg    <= pq_next;
            ld3_reg   <= ld_reg;
            c3_reg    <= c2_reg;
            denom_reg <= denom_next;
            c4_reg    <= c3_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign denom     = denom_reg;
    assign carry     = c4_reg;

endmodule

// ----- hw/rtl/plds_divide.sv -----
module plds_divide (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [plds_pkg::DENOM_W-1:0] denom,
    input  plds_pkg::dist_t              carry,
    output logic                         out_valid,
    output plds_pkg::quot_t              quot
);
    import plds_pkg::*;

    localparam int LAST = DIV_Q_W - 1;

    logic [DIV_Q_W-1:0] v_reg;
    logic [DIV_N_W-1:0] ra_next [DIV_Q_W];
    logic [DIV_N_W-1:0] ra_reg  [DIV_Q_W];
    logic [DIV_N_W-1:0] rb_next [DIV_Q_W];
    logic [DIV_N_W-1:0] rb_reg  [DIV_Q_W];
    logic [DIV_Q_W-1:0] qa_next [DIV_Q_W];
    logic [DIV_Q_W-1:0] qa_reg  [DIV_Q_W];
    logic [DIV_Q_W-1:0] qb_next [DIV_Q_W];
    logic [DIV_Q_W-1:0] qb_reg  [DIV_Q_W];
    logic [DIV_D_W-1:0] da_reg  [DIV_Q_W];
    logic [DIV_D_W-1:0] db_reg  [DIV_Q_W];
    divs_t              side_reg [DIV_Q_W];

    logic [DIV_N_W-1:0] na_entry;
    logic [DIV_D_W-1:0] da_entry;
    divs_t              side_entry;

    // Lane A forms the Lambert quotient, lane B the attenuation quotient.
    always_comb
    begin
        na_entry              = {carry.ndot[NDOT_W-2:0], 1'b0};
        da_entry              = DIV_D_W'(carry.light_dist);
        side_entry.item       = carry.item;
        side_entry.facing     = (carry.light_dist != '0) && !carry.ndot[NDOT_W-1];
        side_entry.att_one    = denom <= DENOM_W'(ONE_Q16);
        side_entry.light_dist = carry.light_dist;
    end

    // Each stage settles one quotient bit of both lanes.
    for (genvar k = 0; k < DIV_Q_W; k++)
    begin : g_step
        localparam int SH = DIV_Q_W - 1 - k;

        logic [DIV_N_W-1:0]   ra_in;
        logic [DIV_N_W-1:0]   rb_in;
        logic [DIV_Q_W-1:0]   qa_in;
        logic [DIV_Q_W-1:0]   qb_in;
        logic [DIV_D_W-1:0]   da_in;
        logic [DIV_D_W-1:0]   db_in;
        divs_t                side_in;
        logic [DIV_CMP_W-1:0] dsa;
        logic [DIV_CMP_W-1:0] dsb;
        logic                 gea;
        logic                 geb;

        if (k == 0)
        begin : g_first
            assign ra_in   = na_entry;
            assign rb_in   = ATT_NUM;
            assign qa_in   = '0;
            assign qb_in   = '0;
            assign da_in   = da_entry;
            assign db_in   = denom;
            assign side_in = side_entry;
        end
        else
        begin : g_rest
            assign ra_in   = ra_reg[k-1];
            assign rb_in   = rb_reg[k-1];
            assign qa_in   = qa_reg[k-1];
            assign qb_in   = qb_reg[k-1];
            assign da_in   = da_reg[k-1];
            assign db_in   = db_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            dsa        = DIV_CMP_W'(da_in) << SH;
            dsb        = DIV_CMP_W'(db_in) << SH;
            gea        = DIV_CMP_W'(ra_in) >= dsa;
            geb        = DIV_CMP_W'(rb_in) >= dsb;
            ra_next[k] = gea ? DIV_N_W'(DIV_CMP_W'(ra_in) - dsa) : ra_in;
            rb_next[k] = geb ? DIV_N_W'(DIV_CMP_W'(rb_in) - dsb) : rb_in;
            qa_next[k] = {qa_in[DIV_Q_W-2:0], gea};
            qb_next[k] = {qb_in[DIV_Q_W-2:0], geb};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ra_reg[k]   <= ra_next[k];
                rb_reg[k]   <= rb_next[k];
                qa_reg[k]   <= qa_next[k];
                qb_reg[k]   <= qb_next[k];
                da_reg[k]   <= da_in;
                db_reg[k]   <= db_in;
                side_reg[k] <= side_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DIV_Q_W-2:0], in_valid};
        end
    end

    assign out_valid  = v_reg[LAST];
    assign quot.side  = side_reg[LAST];
    assign quot.lam   = qa_reg[LAST];
    assign quot.att_q = qb_reg[LAST];

`ifndef ASSERT_OFF
    // A used quotient must leave a remainder below its divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[LAST] && side_reg[LAST].facing)
        |-> (DIV_CMP_W'(ra_reg[LAST]) < DIV_CMP_W'(da_reg[LAST])))
        else $error("Lambert quotient remainder not below the distance.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[LAST] && !side_reg[LAST].att_one)
        |-> (DIV_CMP_W'(rb_reg[LAST]) < DIV_CMP_W'(db_reg[LAST])))
        else $error("Attenuation remainder not below the denominator.");
`endif

endmodule

// ----- hw/rtl/plds_shade.sv -----
module plds_shade (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  plds_pkg::quot_t            quot,
    input  plds_pkg::cfg_t             cfg,
    output logic                       out_valid,
    output logic [plds_pkg::SUM_W-1:0] sum_out_r,
    output logic [plds_pkg::SUM_W-1:0] sum_out_g,
    output logic [plds_pkg::SUM_W-1:0] sum_out_b,
    output logic                       facing_light,
    output logic                       in_shadow,
    output logic                       saturated
);
    import plds_pkg::*;

    localparam int KP_W = ATT_W + DIV_Q_W;
    localparam int SP_W = K_W + SF_W;
    localparam int CP_W = K_W + INTEN_W;
    localparam int S_W  = SUM_W + 1;

    logic [3:0] v_reg;

    logic [ATT_W-1:0]   att;
    logic [KP_W-1:0]    kp;
    logic [K_W-1:0]     k1_next;
    logic [K_W-1:0]     k1_reg;
    logic               sh_next;
    logic               sh1_reg;
    divs_t              side1_reg;

    logic [SP_W-1:0]    sp;
    logic [K_W-1:0]     k2_next;
    logic [K_W-1:0]     k2_reg;
    logic               sh2_reg;
    divs_t              side2_reg;

    logic [INTEN_W-1:0]   inten [3];
    logic [CP_W-1:0]      cp    [3];
    logic [CONTRIB_W-1:0] c_next [3];
    logic [CONTRIB_W-1:0] c_reg  [3];
    logic                 sh3_reg;
    divs_t                side3_reg;

    logic [SUM_W-1:0] sum_in [3];
    logic [S_W-1:0]   s      [3];
    logic [SUM_W-1:0] so_next [3];
    logic [SUM_W-1:0] so_reg  [3];
    logic             sat_next;
    logic             sat_reg;
    logic             facing_reg;
    logic             sh4_reg;

    // First stage: scale the Lambert term by attenuation, decide shadowing.
    always_comb
    begin
        att     = quot.side.att_one ? ONE_Q16 : ATT_W'(quot.att_q[Q16_FRAC-1:0]);
        kp      = KP_W'(att) * KP_W'(quot.lam);
        k1_next = kp[K_W+Q15_FRAC-1:Q15_FRAC];
        sh_next = quot.side.facing && (cfg.shadow < ONE_Q15) && quot.side.item.obs_hit
                  && (quot.side.light_dist > DIST_W'(quot.side.item.obs_dist));
    end

    // Second stage: shadow factor.
    always_comb
    begin
        sp      = SP_W'(k1_reg) * SP_W'(cfg.shadow);
        k2_next = sh1_reg ? sp[K_W+Q15_FRAC-1:Q15_FRAC] : k1_reg;
    end

    // Third stage: per-channel contribution from the light colour.
    assign inten[0] = cfg.intensity[3*INTEN_W-1:2*INTEN_W];
    assign inten[1] = cfg.intensity[2*INTEN_W-1:INTEN_W];
    assign inten[2] = cfg.intensity[INTEN_W-1:0];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cp[c]     = CP_W'(inten[c]) * CP_W'(k2_reg);
            c_next[c] = cp[c][CONTRIB_W+Q8_FRAC-1:Q8_FRAC];
        end
    end

    // Fourth stage: saturating accumulation into the output register.
    assign sum_in[0] = side3_reg.item.sum_r;
    assign sum_in[1] = side3_reg.item.sum_g;
    assign sum_in[2] = side3_reg.item.sum_b;

    always_comb
    begin
        sat_next = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            s[c] = S_W'(sum_in[c]) + (side3_reg.facing ? S_W'(c_reg[c]) : '0);
            if (s[c][S_W-1])
            begin
                so_next[c] = '1;
                sat_next   = 1'b1;
            end
            else
            begin
                so_next[c] = s[c][SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k1_reg     <= k1_next;
            sh1_reg    <= sh_next;
            side1_reg  <= quot.side;
            k2_reg     <= k2_next;
            sh2_reg    <= sh1_reg;
            side2_reg  <= side1_reg;
            for (int c = 0; c < 3; c++)
            begin
                c_reg[c]  <= c_next[c];
                so_reg[c] <= so_next[c];
            end
            sh3_reg    <= sh2_reg;
            side3_reg  <= side2_reg;
            sat_reg    <= sat_next;
            facing_reg <= side3_reg.facing;
            sh4_reg    <= sh3_reg;
        end
    end

    assign out_valid    = v_reg[3];
    assign sum_out_r    = so_reg[0];
    assign sum_out_g    = so_reg[1];
    assign sum_out_b    = so_reg[2];
    assign facing_light = facing_reg;
    assign in_shadow    = sh4_reg;
    assign saturated    = sat_reg;

`ifndef ASSERT_OFF
    // Clipping and shadowing can only follow from an added contribution.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[3] && sat_reg) |-> facing_reg)
        else $error("Saturation flagged on an item that added nothing.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[3] && sh4_reg) |-> facing_reg)
        else $error("Shadow flagged on an item that added nothing.");
`endif

endmodule

// ----- dv/tb_point_light_diffuse_shade.sv -----
`timescale 1ns / 100ps

module tb_point_light_diffuse_shade;

    import plds_pkg::*;

    localparam int  HALF_PERIOD = 4;
    localparam int  LATENCY     = 64;
    localparam int  PHASE_ITEMS = 115;
    localparam int  HOLD_CYCLES = 400;
    localparam int  CYCLE_LIMIT = 400000;
    localparam logic [63:0] ATT_LIMIT = 64'h100_0000_0000;
    localparam logic [31:0] SUM_TOP   = 32'hFFFF_FFFF;

    // One input transaction and one result transaction.
    typedef struct {
        logic signed [COORD_W-1:0] sx, sy, sz;
        logic signed [NORM_W-1:0]  nx, ny, nz;
        logic                      hit;
        logic [SUM_W-1:0]          odist;
        logic [SUM_W-1:0]          r, g, b;
    } point_t;

    typedef struct {
        logic [SUM_W-1:0] r, g, b;
        logic             facing, shadow, sat;
    } shade_t;

    typedef struct {
        point_t pt;
        bit     typed;
        shade_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [COORD_W-1:0] surf_x = '0, surf_y = '0, surf_z = '0;
    logic signed [NORM_W-1:0] norm_x = '0, norm_y = '0, norm_z = '0;
    logic obstruction_hit = 1'b0;
    logic [SUM_W-1:0] obstruction_dist = '0;
    logic [SUM_W-1:0] sum_in_r = '0, sum_in_g = '0, sum_in_b = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [SUM_W-1:0] sum_out_r, sum_out_g, sum_out_b;
    logic facing_light, in_shadow, saturated;

    cfg_t   light_cfg;
    shade_t pending_shades[$];
    int     fail_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_request = 0;

    point_light_diffuse_shade u_top (.*);

    always #HALF_PERIOD clk = ~clk;

    // Q16.16 product, truncated and capped at 2^40.
    function automatic logic [63:0] q16_mul_capped(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = (128'(a) * 128'(b)) >> 16;
        return (p > 128'(ATT_LIMIT)) ? ATT_LIMIT : p[63:0];
    endfunction

    // Shades one surface point against the current light settings.
    function automatic shade_t shade_point(point_t pt);
        longint dx, dy, dz, ndot;
        logic [63:0] hx, hy, hz, rem, root, bt, light_dist, obs_inten;
        logic [127:0] denom, att, lam, k, s;
        shade_t res;
        dx = longint'(light_cfg.pos_x) - longint'(pt.sx);
        dy = longint'(light_cfg.pos_y) - longint'(pt.sy);
        dz = longint'(light_cfg.pos_z) - longint'(pt.sz);
        ndot = longint'(pt.nx) * dx + longint'(pt.ny) * dy + longint'(pt.nz) * dz;
        hx = 64'((dx < 0) ? -dx : dx) >> 1;
        hy = 64'((dy < 0) ? -dy : dy) >> 1;
        hz = 64'((dz < 0) ? -dz : dz) >> 1;
        rem = hx * hx + hy * hy + hz * hz;
        root = 0;
        bt = 64'd1 << 62;
        while (bt > rem)
            bt >>= 2;
        while (bt != 0)
        begin
            if (rem >= root + bt)
            begin
                rem -= root + bt;
                root = (root >> 1) + bt;
            end
            else
                root >>= 1;
            bt >>= 2;
        end
        light_dist = root << 1;
        res = '{pt.r, pt.g, pt.b, 1'b0, 1'b0, 1'b0};
        if (light_dist != 0 && ndot >= 0)
        begin
            res.facing = 1'b1;
            denom = 128'(light_cfg.att_c) + 128'(q16_mul_capped(light_cfg.att_l, light_dist))
                  + 128'(q16_mul_capped(light_cfg.att_q,
                                        q16_mul_capped(light_dist, light_dist)));
            att = (denom <= 128'(ONE_Q16)) ? 128'(ONE_Q16) : (128'd1 << 32) / denom;
            lam = (128'(ndot) << 1) / 128'(light_dist);
            k = (att * lam) >> 15;
            if (light_cfg.shadow < ONE_Q15 && pt.hit && light_dist > 64'(pt.odist))
            begin
                res.shadow = 1'b1;
                k = (k * 128'(light_cfg.shadow)) >> 15;
            end
            for (int c = 0; c < 3; c++)
            begin
                obs_inten = 64'(light_cfg.intensity[47 - 16 * c -: 16]);
                s = ((128'(obs_inten) * k) >> 8)
                  + 128'((c == 0) ? pt.r : (c == 1) ? pt.g : pt.b);
                if (s > 128'(SUM_TOP))
                begin
                    s = 128'(SUM_TOP);
                    res.sat = 1'b1;
                end
                if (c == 0) res.r = s[31:0];
                else if (c == 1) res.g = s[31:0];
                else res.b = s[31:0];
            end
        end
        return res;
    endfunction

    function automatic point_t make_point(int sx, int sy, int sz, int nx, int ny, int nz,
                                          bit hit, int unsigned od, int unsigned r,
                                          int unsigned g, int unsigned b);
        point_t pt;
        pt = '{sx, sy, sz, 16'(nx), 16'(ny), 16'(nz), hit, od, r, g, b};
        return pt;
    endfunction

    // Writes one register; load_light mirrors the whole light into the local copy.
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= data;
    endtask

    task automatic load_light(cfg_t c);
        write_reg(CFG_INTENSITY, c.intensity);
        write_reg(CFG_POS_X, CFG_DATA_W'(unsigned'(c.pos_x)));
        write_reg(CFG_POS_Y, CFG_DATA_W'(unsigned'(c.pos_y)));
        write_reg(CFG_POS_Z, CFG_DATA_W'(unsigned'(c.pos_z)));
        write_reg(CFG_SHADOW, CFG_DATA_W'(c.shadow));
        write_reg(CFG_ATT_C, CFG_DATA_W'(c.att_c));
        write_reg(CFG_ATT_L, CFG_DATA_W'(c.att_l));
        write_reg(CFG_ATT_Q, CFG_DATA_W'(c.att_q));
        @(negedge clk);
        cfg_wen <= 1'b0;
        light_cfg = c;
    endtask

    // Offers one transaction and records its expected shade on acceptance.
    task automatic offer_point(point_t pt, bit typed, shade_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        surf_x <= pt.sx;
        surf_y <= pt.sy;
        surf_z <= pt.sz;
        norm_x <= pt.nx;
        norm_y <= pt.ny;
        norm_z <= pt.nz;
        obstruction_hit <= pt.hit;
        obstruction_dist <= pt.odist;
        sum_in_r <= pt.r;
        sum_in_g <= pt.g;
        sum_in_b <= pt.b;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        pending_shades.push_back(typed ? want : shade_point(pt));
    endtask

    // Lowers valid and waits until every result has come back.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_shades.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic cfg_t pick_light(int kind);
        cfg_t c;
        case (kind)
            0: c = '{48'({$urandom, $urandom}), $urandom, $urandom, $urandom,
                     16'($urandom), $urandom, $urandom, $urandom};
            1: c = '{48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            2: c = '{48'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     16'h0, 32'h0, 32'h0, 32'h0};
            3: c = '{48'hFFFF_FFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                     16'h8000, 32'h0, 32'h0, 32'h0};
            default:
                c = '{{16'($urandom_range(0, 16'h0800)), 16'($urandom_range(0, 16'h0800)),
                       16'($urandom_range(0, 16'h0800))},
                      $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                      $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                      $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                      16'($urandom_range(0, 32767)), $urandom_range(0, 32'h0002_0000),
                      $urandom_range(0, 32'h0000_4000), $urandom_range(0, 32'h0000_0400)};
        endcase
        return c;
    endfunction

    // Random point: mostly near the light with a normal aimed at it.
    function automatic point_t pick_point();
        point_t pt;
        int unsigned spread;
        longint d;
        pt.sx = $urandom;
        pt.sy = $urandom;
        pt.sz = $urandom;
        pt.nx = 16'($urandom);
        pt.ny = 16'($urandom);
        pt.nz = 16'($urandom);
        if ($urandom_range(0, 9) < 8)
        begin
            spread = 1 << $urandom_range(2, 26);
            pt.sx = light_cfg.pos_x + $signed($urandom_range(0, spread)) - $signed(spread / 2);
            pt.sy = light_cfg.pos_y + $signed($urandom_range(0, spread)) - $signed(spread / 2);
            pt.sz = light_cfg.pos_z + $signed($urandom_range(0, spread)) - $signed(spread / 2);
            if ($urandom_range(0, 3) != 0)
            begin
                d = longint'(light_cfg.pos_x) - longint'(pt.sx);
                pt.nx = 16'((d < 0) ? -$urandom_range(0, 16384) : $urandom_range(0, 16384));
                d = longint'(light_cfg.pos_y) - longint'(pt.sy);
                pt.ny = 16'((d < 0) ? -$urandom_range(0, 16384) : $urandom_range(0, 16384));
                d = longint'(light_cfg.pos_z) - longint'(pt.sz);
                pt.nz = 16'((d < 0) ? -$urandom_range(0, 16384) : $urandom_range(0, 16384));
            end
        end
        pt.hit = $urandom_range(0, 1);
        pt.odist = $urandom_range(0, 1) ? $urandom : $urandom_range(0, spread);
        pt.r = $urandom_range(0, 3) == 0 ? SUM_TOP - $urandom_range(0, 32'hFFFFF) : $urandom;
        pt.g = $urandom_range(0, 3) == 0 ? SUM_TOP - $urandom_range(0, 32'hFFFFF) : $urandom;
        pt.b = $urandom_range(0, 3) == 0 ? SUM_TOP - $urandom_range(0, 32'hFFFFF) : $urandom;
        return pt;
    endfunction

    // The receiver stalls at random, or holds off for a long stretch on request.
    always @(negedge clk)
    begin
        int hold_left;
        if (hold_request)
        begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Each result transaction is compared with the oldest expected shade.
    always @(posedge clk)
    begin
        shade_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_shades.size() == 0)
            begin
                $error("result with no expected shade waiting");
                fail_count++;
            end
            else
            begin
                want = pending_shades.pop_front();
                if (sum_out_r !== want.r)
                begin
                    $error("sum_out_r: expected %h, got %h", want.r, sum_out_r);
                    fail_count++;
                end
                if (sum_out_g !== want.g)
                begin
                    $error("sum_out_g: expected %h, got %h", want.g, sum_out_g);
                    fail_count++;
                end
                if (sum_out_b !== want.b)
                begin
                    $error("sum_out_b: expected %h, got %h", want.b, sum_out_b);
                    fail_count++;
                end
                if (facing_light !== want.facing)
                begin
                    $error("facing_light: expected %b, got %b", want.facing, facing_light);
                    fail_count++;
                end
                if (in_shadow !== want.shadow)
                begin
                    $error("in_shadow: expected %b, got %b", want.shadow, in_shadow);
                    fail_count++;
                end
                if (saturated !== want.sat)
                begin
                    $error("saturated: expected %b, got %b", want.sat, saturated);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_point_light_diffuse_shade failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        shade_t none;
        int kinds[7] = '{4, 0, 1, 4, 2, 3, 4};
        none = '{0, 0, 0, 0, 0, 0};
        light_cfg = '{48'h0100_0100_0100, 0, 0, 0, ONE_Q15, 32'(ONE_Q16), 0, 0};

        // Directed rows under the reset settings: unit light at the origin.
        rows.push_back('{make_point(0, 0, 0, 16384, 0, 0, 1, 0, 5, 6, 7), 1,
                         '{5, 6, 7, 0, 0, 0}});
        rows.push_back('{make_point(65536, 0, 0, 16384, 0, 0, 0, 0, 9, 9, 9), 1,
                         '{9, 9, 9, 0, 0, 0}});
        rows.push_back('{make_point(-65536, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0), 1,
                         '{65536, 65536, 65536, 1, 0, 0}});
        rows.push_back('{make_point(-65536, 0, 0, 16384, 0, 0, 0, 0, '1, '1, '1), 1,
                         '{'1, '1, '1, 1, 0, 1}});
        rows.push_back('{make_point(-65536, 0, 0, 0, 0, 0, 0, 0, 3, 4, 5), 1,
                         '{3, 4, 5, 1, 0, 0}});
        rows.push_back('{make_point(-65536, 0, 0, 16384, 0, 0, 1, 0, 0, 0, 0), 1,
                         '{65536, 65536, 65536, 1, 0, 0}});
        rows.push_back('{make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    16'h8000, 16'h8000, 16'h8000, 1, '1, 0, 0, 0), 0, none});
        rows.push_back('{make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 0, 1, 2, 3), 0, none});
        rows.push_back('{make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    16'h8000, 16'h8000, 16'h8000, 0, '1, '1, 0, '1), 0, none});
        rows.push_back('{make_point(-3, -1, -2, 32767, 32767, 32767, 1, 1, 0, 0, 0), 0, none});
        rows.push_back('{make_point(-1, 0, 0, 16384, 0, 0, 0, 0, 7, 7, 7), 0, none});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            offer_point(rows[i].pt, rows[i].typed, rows[i].want);
        drain_pipeline();

        // Random phases, each with its own light and idling pattern.
        foreach (kinds[p])
        begin
            load_light(pick_light(kinds[p]));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            if (p == 4)
                hold_request = 1;
            // A shadowing phase also gets points behind and in front of the obstruction.
            if (p == 6)
            begin
                offer_point(make_point(light_cfg.pos_x - 65536, light_cfg.pos_y,
                                       light_cfg.pos_z, 16384, 0, 0, 1, 65536, 0, 0, 0),
                            0, none);
                offer_point(make_point(light_cfg.pos_x - 65536, light_cfg.pos_y,
                                       light_cfg.pos_z, 16384, 0, 0, 1, 100, 0, 0, 0),
                            0, none);
            end
            repeat (PHASE_ITEMS)
                offer_point(pick_point(), 0, none);
            drain_pipeline();
        end

        if (fail_count == 0)
            $display("tb_point_light_diffuse_shade passed");
        else
            $display("tb_point_light_diffuse_shade failed");
        $finish;
    end

endmodule

// ----- point_light_diffuse_shade.f -----
hw/rtl/plds_pkg.sv
hw/rtl/plds_geom.sv
hw/rtl/plds_isqrt.sv
hw/rtl/plds_atten.sv
hw/rtl/plds_divide.sv
hw/rtl/plds_shade.sv
hw/rtl/point_light_diffuse_shade.sv
dv/tb_point_light_diffuse_shade.sv
